// ===== rtl/survival_curve_sampler_assert.svh =====
// ----------------------------------------------------------------------------
// survival_curve_sampler assertion macros
// Immediate-implication and next-cycle-implication property shorthands.
// ----------------------------------------------------------------------------
`ifndef SURVIVAL_CURVE_SAMPLER_ASSERT_SVH
`define SURVIVAL_CURVE_SAMPLER_ASSERT_SVH

// check cons in the same cycle as ante
`define SCS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("survival_curve_sampler assertion failed");

// check cons in the cycle after ante
`define SCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("survival_curve_sampler assertion failed");

`endif

// ===== rtl/scs_pkg.sv =====
// ----------------------------------------------------------------------------
// scs_pkg
// Shared widths, request codes, types and the xorshift step function.
// ----------------------------------------------------------------------------
`default_nettype none

package scs_pkg;

    localparam int TABLE_DEPTH    = 1024;
    localparam int ROW_W          = $clog2(TABLE_DEPTH);
    localparam int TIME_W         = 32;
    localparam int SURV_W         = 17;
    localparam int COUNT_W        = 11;
    localparam int RNG_W          = 32;
    localparam int PROB_FRAC_BITS = 16;

    localparam logic [RNG_W-1:0] SEED_DEFAULT = RNG_W'(1);

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_DRAW = 1'b1;

    typedef struct packed {
        logic [COUNT_W-1:0] point_count;
        logic [ROW_W-1:0]   start_row;
        logic [SURV_W-1:0]  surv_value;
        logic [TIME_W-1:0]  time_value;
        logic [ROW_W-1:0]   row_index;
        logic               req_type;
    } scs_req_t;

    typedef struct packed {
        logic               en;
        logic [ROW_W-1:0]   addr;
        logic [TIME_W-1:0]  time_value;
        logic [SURV_W-1:0]  surv_value;
    } scs_mem_wr_t;

    function automatic logic [RNG_W-1:0] xorshift32(input logic [RNG_W-1:0] x);
        logic [RNG_W-1:0] a;
        logic [RNG_W-1:0] b;
        a = x ^ (x << 13);
        b = a ^ (a >> 17);
        return b ^ (b << 5);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/scs_ram.sv =====
// ----------------------------------------------------------------------------
// scs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module scs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire                      clk,
    input  wire                      wr_en,
    input  wire  [$clog2(DEPTH)-1:0] wr_addr,
    input  wire  [WIDTH-1:0]         wr_data,
    input  wire  [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/scs_urng.sv =====
// ----------------------------------------------------------------------------
// scs_urng
// 32-bit xorshift generator state, seeded by configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

module scs_urng (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_wr_en,
    input  wire  [scs_pkg::RNG_W-1:0]     cfg_wr_data,
    input  wire                           step,
    output logic [scs_pkg::RNG_W-1:0]     rng_state
);

    logic [scs_pkg::RNG_W-1:0] rng_reg;
    logic [scs_pkg::RNG_W-1:0] rng_next;

    always_comb
    begin
        rng_next = rng_reg;
        if (cfg_wr_en)
        begin
            rng_next = (cfg_wr_data == '0) ? scs_pkg::SEED_DEFAULT : cfg_wr_data;
        end
        else if (step)
        begin
            rng_next = scs_pkg::xorshift32(rng_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rng_reg <= scs_pkg::SEED_DEFAULT;
        end
        else
        begin
            rng_reg <= rng_next;
        end
    end

    assign rng_state = rng_reg;

endmodule

`default_nettype wire

// ===== rtl/scs_walker.sv =====
// ----------------------------------------------------------------------------
// scs_walker
// Request sequencer: table loads, curve walk with one shared multiplier and
// comparator, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module scs_walker #(
    parameter int PROB_FRAC_BITS = scs_pkg::PROB_FRAC_BITS
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              req_valid,
    output logic                             req_ready,
    input  scs_pkg::scs_req_t                req,
    input  wire  [scs_pkg::RNG_W-1:0]        rng_state,
    output logic                             rng_step,
    output scs_pkg::scs_mem_wr_t             mem_wr,
    output logic [scs_pkg::ROW_W-1:0]        rd_addr,
    input  wire  [scs_pkg::TIME_W-1:0]       time_q,
    input  wire  [scs_pkg::SURV_W-1:0]       surv_q,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [scs_pkg::TIME_W-1:0]       out_time,
    output logic                             out_none
);

    localparam int PROD_W = PROB_FRAC_BITS + scs_pkg::SURV_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREV_RD,
        ST_PREV_LD,
        ST_FETCH,
        ST_MULT,
        ST_CMP,
        ST_RESULT
    } state_t;

    state_t                       state_reg;
    logic [scs_pkg::ROW_W-1:0]    addr_reg;
    logic [scs_pkg::COUNT_W-1:0]  rem_reg;
    logic [scs_pkg::SURV_W-1:0]   prev_reg;
    logic [PROD_W-1:0]            prod_reg;
    logic [scs_pkg::TIME_W-1:0]   hit_time_reg;
    logic                         hit_none_reg;
    logic                         out_valid_reg;
    logic [scs_pkg::TIME_W-1:0]   out_time_reg;
    logic                         out_none_reg;

    logic                         accept;
    logic                         out_load;
    logic [PROB_FRAC_BITS-1:0]    uniform;
    logic [PROD_W-1:0]            prod_next;
    logic [PROD_W-1:0]            thresh;
    logic                         fire;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign out_load  = (state_reg == ST_RESULT) && (!out_valid_reg || out_ready);
    assign uniform   = rng_state[scs_pkg::RNG_W-1 -: PROB_FRAC_BITS];
    assign prod_next = PROD_W'(uniform) * PROD_W'(prev_reg);
    assign thresh    = {surv_q, {PROB_FRAC_BITS{1'b0}}};
    assign fire      = prod_reg > thresh;
    assign rng_step  = (state_reg == ST_FETCH);
    assign rd_addr   = addr_reg;

    always_comb
    begin
        mem_wr.en         = accept && (req.req_type == scs_pkg::REQ_LOAD);
        mem_wr.addr       = req.row_index;
        mem_wr.time_value = req.time_value;
        mem_wr.surv_value = req.surv_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_time_reg  <= hit_time_reg;
                out_none_reg  <= hit_none_reg;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (req.req_type == scs_pkg::REQ_DRAW))
                    begin
                        addr_reg <= req.start_row;
                        rem_reg  <= req.point_count - scs_pkg::COUNT_W'(2);
                        if (req.point_count < scs_pkg::COUNT_W'(3))
                        begin
                            hit_time_reg <= '0;
                            hit_none_reg <= 1'b1;
                            state_reg    <= ST_RESULT;
                        end
                        else
                        begin
                            state_reg <= ST_PREV_RD;
                        end
                    end
                end
                ST_PREV_RD:
                begin
                    state_reg <= ST_PREV_LD;
                end
                ST_PREV_LD:
                begin
                    prev_reg  <= surv_q;
                    addr_reg  <= addr_reg + scs_pkg::ROW_W'(1);
                    state_reg <= ST_FETCH;
                end
                ST_FETCH:
                begin
                    state_reg <= ST_MULT;
                end
                ST_MULT:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    prev_reg <= surv_q;
                    if (fire)
                    begin
                        hit_time_reg <= time_q;
                        hit_none_reg <= 1'b0;
                        state_reg    <= ST_RESULT;
                    end
                    else if (rem_reg == scs_pkg::COUNT_W'(1))
                    begin
                        hit_time_reg <= '0;
                        hit_none_reg <= 1'b1;
                        state_reg    <= ST_RESULT;
                    end
                    else
                    begin
                        rem_reg   <= rem_reg - scs_pkg::COUNT_W'(1);
                        addr_reg  <= addr_reg + scs_pkg::ROW_W'(1);
                        state_reg <= ST_FETCH;
                    end
                end
                ST_RESULT:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_time  = out_time_reg;
    assign out_none  = out_none_reg;

endmodule

`default_nettype wire

// ===== rtl/survival_curve_sampler.sv =====
// ----------------------------------------------------------------------------
// survival_curve_sampler
// Survival curve table with a random event-time draw per request.
// ----------------------------------------------------------------------------
// A load (tuser 0) writes one (time, survival) point into the table and gives
// no result. A draw (tuser 1) walks the curve from the row after start_row
// through the second-to-last point and returns one result: the time of the
// first row that fires, or tuser 1 with data 0 for no event. It holds the input
// side until that result is registered, skipping the walk when point_count is
// below 3; each row is tested in a fetch, a multiply and a compare state on the
// single table read port, the shared multiplier and the comparator. The result
// sits in an output register, so loads are taken while it waits on the output
// side.
// ----------------------------------------------------------------------------
`default_nettype none

module survival_curve_sampler #(
    parameter int PROB_FRAC_BITS = scs_pkg::PROB_FRAC_BITS
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_wr_en,
    input  wire  [31:0] cfg_wr_data,      // rng_seed
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [79:0] s_axis_tdata,     // row_index, time_value, surv_value,
                                          // start_row, point_count
    input  wire  [0:0]  s_axis_tuser,     // req_type
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,     // event_time
    output logic [0:0]  m_axis_tuser      // no_event
);

    scs_pkg::scs_req_t                req;
    scs_pkg::scs_mem_wr_t             mem_wr;
    logic [scs_pkg::RNG_W-1:0]        rng_state;
    logic                             rng_step;
    logic [scs_pkg::ROW_W-1:0]        rd_addr;
    logic [scs_pkg::TIME_W-1:0]       time_q;
    logic [scs_pkg::SURV_W-1:0]       surv_q;
    logic                             out_none;

    always_comb
    begin
        req.req_type    = s_axis_tuser[0];
        req.row_index   = s_axis_tdata[9:0];
        req.time_value  = s_axis_tdata[41:10];
        req.surv_value  = s_axis_tdata[58:42];
        req.start_row   = s_axis_tdata[68:59];
        req.point_count = s_axis_tdata[79:69];
    end

    scs_urng u_urng (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (rng_step),
        .rng_state   (rng_state)
    );

    scs_ram #(
        .WIDTH (scs_pkg::TIME_W),
        .DEPTH (scs_pkg::TABLE_DEPTH)
    ) u_time_ram (
        .clk     (clk),
        .wr_en   (mem_wr.en),
        .wr_addr (mem_wr.addr),
        .wr_data (mem_wr.time_value),
        .rd_addr (rd_addr),
        .rd_data (time_q)
    );

    scs_ram #(
        .WIDTH (scs_pkg::SURV_W),
        .DEPTH (scs_pkg::TABLE_DEPTH)
    ) u_surv_ram (
        .clk     (clk),
        .wr_en   (mem_wr.en),
        .wr_addr (mem_wr.addr),
        .wr_data (mem_wr.surv_value),
        .rd_addr (rd_addr),
        .rd_data (surv_q)
    );

    scs_walker #(
        .PROB_FRAC_BITS (PROB_FRAC_BITS)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .req       (req),
        .rng_state (rng_state),
        .rng_step  (rng_step),
        .mem_wr    (mem_wr),
        .rd_addr   (rd_addr),
        .time_q    (time_q),
        .surv_q    (surv_q),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_time  (m_axis_tdata),
        .out_none  (out_none)
    );

    assign m_axis_tuser = out_none;

endmodule

`default_nettype wire

// ===== rtl/scs_checker.sv =====
// ----------------------------------------------------------------------------
// scs_checker
// Port-level checks on the sampler's streams, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "survival_curve_sampler_assert.svh"

module scs_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire [0:0]  s_axis_tuser,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [31:0] m_axis_tdata,
    input wire [0:0]  m_axis_tuser
);

    logic        out_wait;
    logic        out_none;
    logic        draw_xfer;
    logic        load_xfer;
    logic [32:0] out_word;

    assign out_wait  = m_axis_tvalid && !m_axis_tready;
    assign out_none  = m_axis_tvalid && m_axis_tuser[0];
    assign draw_xfer = s_axis_tvalid && s_axis_tready && s_axis_tuser[0];
    assign load_xfer = s_axis_tvalid && s_axis_tready && !s_axis_tuser[0];
    assign out_word  = {m_axis_tuser, m_axis_tdata};

    `SCS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, m_axis_tvalid && $stable(out_word))
    `SCS_ASSERT_SAME(a_none_zero, clk, rst_n, out_none, m_axis_tdata == 32'd0)
    `SCS_ASSERT_NEXT(a_draw_busy, clk, rst_n, draw_xfer, !s_axis_tready)
    `SCS_ASSERT_NEXT(a_load_ready, clk, rst_n, load_xfer, s_axis_tready)

endmodule

bind survival_curve_sampler scs_checker u_scs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// survival_curve_sampler testbench
// Fills the curve table, runs a short directed plan of loads and draws, then
// random phases of curve loads followed by draws, with noise loads and draws
// mixed in. Each draw is predicted in the bench, including the xorshift
// stream, and every output transfer is compared with the oldest prediction.
// Phases change the generator seed and the idle pattern on both stream sides.
// ----------------------------------------------------------------------------

module tb;

    import scs_pkg::*;

    localparam int          PHASE_ITEMS   = 215;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          TAIL_CYCLES   = 20;
    localparam int unsigned LIMIT_CYCLES  = 3_000_000;

    typedef enum {FLOW_FREE, FLOW_SENDER_IDLE, FLOW_RECEIVER_STALL, FLOW_BOTH} flow_mode_t;

    typedef struct packed {
        logic [TIME_W-1:0] event_time;
        logic              no_event;
    } draw_result_t;

    typedef struct {
        logic               kind;
        logic [ROW_W-1:0]   row;
        logic [TIME_W-1:0]  tick;
        logic [SURV_W-1:0]  surv;
        logic [COUNT_W-1:0] npts;
        bit                 typed;
        logic [TIME_W-1:0]  want_time;
        logic               want_none;
    } plan_row_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [31:0] cfg_wr_data   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata  = '0;
    logic [0:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    logic [TIME_W-1:0] tick_table [TABLE_DEPTH];
    logic [SURV_W-1:0] surv_table [TABLE_DEPTH];
    logic [RNG_W-1:0]  gen_state;
    draw_result_t      pending_draws [$];

    flow_mode_t  flow_mode     = FLOW_BOTH;
    int          items_sent    = 0;
    int          mismatches    = 0;
    int          hold_requests = 0;
    int          hold_seen     = 0;
    int unsigned hold_left     = 0;
    int unsigned cycle_count   = 0;

    plan_row_t opening_plan [24] = '{
        '{REQ_DRAW, 10'd5,    32'd0,           17'd0,     11'd0,    1'b1, 32'd0, 1'b1},
        '{REQ_DRAW, 10'd5,    32'd0,           17'd0,     11'd1,    1'b1, 32'd0, 1'b1},
        '{REQ_DRAW, 10'd5,    32'd0,           17'd0,     11'd2,    1'b1, 32'd0, 1'b1},
        '{REQ_LOAD, 10'd1020, 32'd0,           17'd0,     11'd0,    1'b0, 32'd0, 1'b0},
        '{REQ_LOAD, 10'd1021, 32'hFFFF_FFFF,   17'd0,     11'd0,    1'b0, 32'd0, 1'b0},
        '{REQ_LOAD, 10'd1022, 32'h1234_5678,   17'd0,     11'd0,    1'b0, 32'd0, 1'b0},
        '{REQ_LOAD, 10'd1023, 32'hFFFF_FFFF,   17'd0,     11'd0,    1'b0, 32'd0, 1'b0},
        '{REQ_LOAD, 10'd0,    32'd0,           17'd0,     11'd0,    1'b0, 32'd0, 1'b0},
        '{REQ_DRAW, 10'd1020, 32'd0,           17'd0,     11'd6,    1'b1, 32'd0, 1'b1},
        '{REQ_LOAD, 10'd200,  32'd10,          17'd65536, 11'd0,    1'b0, 32'd0, 1'b0},
        '{REQ_LOAD, 10'd201,  32'd20,          17'd65536, 11'd0,    1'b0, 32'd0, 1'b0},
        '{REQ_LOAD, 10'd202,  32'd30,          17'd65536, 11'd0,    1'b0, 32'd0, 1'b0},
        '{REQ_LOAD, 10'd203,  32'd40,          17'd65536, 11'd0,    1'b0, 32'd0, 1'b0},
        '{REQ_DRAW, 10'd200,  32'd0,           17'd0,     11'd4,    1'b1, 32'd0, 1'b1},
        '{REQ_LOAD, 10'd300,  32'd7,           17'd65536, 11'd0,    1'b0, 32'd0, 1'b0},
        '{REQ_LOAD, 10'd301,  32'hFFFF_FFFF,   17'd0,     11'd0,    1'b0, 32'd0, 1'b0},
        '{REQ_LOAD, 10'd302,  32'd9,           17'd65536, 11'd0,    1'b0, 32'd0, 1'b0},
        '{REQ_DRAW, 10'd300,  32'd0,           17'd0,     11'd3,    1'b0, 32'd0, 1'b0},
        '{REQ_LOAD, 10'd400,  32'd5,           17'd65536, 11'd0,    1'b0, 32'd0, 1'b0},
        '{REQ_LOAD, 10'd401,  32'd0,           17'd0,     11'd0,    1'b0, 32'd0, 1'b0},
        '{REQ_LOAD, 10'd402,  32'd1,           17'd131071, 11'd0,   1'b0, 32'd0, 1'b0},
        '{REQ_DRAW, 10'd400,  32'd0,           17'd0,     11'd3,    1'b0, 32'd0, 1'b0},
        '{REQ_DRAW, 10'd0,    32'd0,           17'd0,     11'd1024, 1'b0, 32'd0, 1'b0},
        '{REQ_DRAW, 10'd1023, 32'd0,           17'd0,     11'd2047, 1'b0, 32'd0, 1'b0}
    };

    survival_curve_sampler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // walk the curve, one generator step per tested row
    function automatic draw_result_t sample_event(input logic [ROW_W-1:0] first,
                                                  input logic [COUNT_W-1:0] npts);
        draw_result_t       res;
        logic [ROW_W-1:0]   cur_row;
        logic [ROW_W-1:0]   prev_row;
        logic [RNG_W-1:0]   x;
        logic [RNG_W-1:0]   u;
        logic [2*RNG_W-1:0] weighted;
        logic [2*RNG_W-1:0] scaled;
        int                 n;
        res.event_time = '0;
        res.no_event   = 1'b1;
        n = int'(npts);
        for (int k = 1; k + 1 < n; k++)
        begin
            cur_row  = first + ROW_W'(k);
            prev_row = cur_row - ROW_W'(1);
            x = gen_state;
            x = x ^ (x << 13);
            x = x ^ (x >> 17);
            x = x ^ (x << 5);
            gen_state = x;
            u = x >> (RNG_W - PROB_FRAC_BITS);
            weighted = (2*RNG_W)'(u) * (2*RNG_W)'(surv_table[prev_row]);
            scaled   = (2*RNG_W)'(surv_table[cur_row]) << PROB_FRAC_BITS;
            if (weighted > scaled)
            begin
                res.event_time = tick_table[cur_row];
                res.no_event   = 1'b0;
                break;
            end
        end
        return res;
    endfunction

    function automatic scs_req_t make_load(input logic [ROW_W-1:0] row,
                                           input logic [TIME_W-1:0] tick,
                                           input logic [SURV_W-1:0] surv);
        scs_req_t r;
        r.req_type    = REQ_LOAD;
        r.row_index   = row;
        r.time_value  = tick;
        r.surv_value  = surv;
        r.start_row   = ROW_W'($urandom);
        r.point_count = COUNT_W'($urandom);
        return r;
    endfunction

    function automatic scs_req_t make_draw(input logic [ROW_W-1:0] first,
                                           input logic [COUNT_W-1:0] npts);
        scs_req_t r;
        r.req_type    = REQ_DRAW;
        r.row_index   = ROW_W'($urandom);
        r.time_value  = $urandom;
        r.surv_value  = SURV_W'($urandom);
        r.start_row   = first;
        r.point_count = npts;
        return r;
    endfunction

    function automatic bit sender_pauses();
        case (flow_mode)
            FLOW_SENDER_IDLE: return $urandom_range(0, 99) < 83;
            FLOW_BOTH:        return $urandom_range(0, 99) < 31;
            default:          return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (flow_mode)
            FLOW_RECEIVER_STALL: return $urandom_range(0, 99) < 83;
            FLOW_BOTH:           return $urandom_range(0, 99) < 31;
            default:             return 1'b0;
        endcase
    endfunction

    task automatic send_req(input scs_req_t r, input bit typed, input draw_result_t want);
        draw_result_t res;
        while (sender_pauses())
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.req_type;
        s_axis_tdata  <= {r.point_count, r.start_row, r.surv_value, r.time_value, r.row_index};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        if (r.req_type == REQ_LOAD)
        begin
            tick_table[r.row_index] = r.time_value;
            surv_table[r.row_index] = r.surv_value;
        end
        else
        begin
            res = sample_event(r.start_row, r.point_count);
            pending_draws.push_back(typed ? want : res);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_draws.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] seed);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= seed;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        gen_state = (seed == '0) ? SEED_DEFAULT : seed;
    endtask

    // one curve segment per run of rows, survival falling in random steps
    task automatic fill_table();
        logic [SURV_W-1:0] level;
        logic [TIME_W-1:0] tick;
        level = 17'd65536;
        tick  = '0;
        for (int row = 0; row < TABLE_DEPTH; row++)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                level = 17'd65536;
                tick  = $urandom_range(0, 100);
            end
            else if ($urandom_range(0, 2) == 0)
                level = level - SURV_W'($urandom_range(0, level / 4));
            send_req(make_load(ROW_W'(row), tick, level), 1'b0, '0);
            tick = tick + $urandom_range(1, 3000);
        end
    endtask

    task automatic send_curve();
        logic [ROW_W-1:0]   first;
        logic [SURV_W-1:0]  level;
        logic [TIME_W-1:0]  tick;
        logic [COUNT_W-1:0] npts;
        int                 len;
        first = ROW_W'($urandom);
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 16);
        level = ($urandom_range(0, 3) == 0) ? SURV_W'($urandom_range(1, 65536)) : 17'd65536;
        tick  = $urandom_range(0, 50);
        for (int k = 0; k < len; k++)
        begin
            send_req(make_load(first + ROW_W'(k), tick, level), 1'b0, '0);
            tick = tick + $urandom_range(1, 5000);
            if ($urandom_range(0, 19) == 0)
                level = '0;
            else if ($urandom_range(0, 2) != 0)
                level = level - SURV_W'($urandom_range(0, level / 3));
        end
        repeat ($urandom_range(1, 4))
        begin
            npts = ($urandom_range(0, 3) == 0) ? COUNT_W'($urandom_range(0, len)) : COUNT_W'(len);
            send_req(make_draw(first, npts), 1'b0, '0);
        end
    endtask

    task automatic check_draw_result();
        draw_result_t want;
        if (pending_draws.size() == 0)
        begin
            $error("result with no draw pending: event_time %0h no_event %0b",
                   m_axis_tdata, m_axis_tuser);
            mismatches++;
        end
        else
        begin
            want = pending_draws.pop_front();
            if (m_axis_tdata !== want.event_time)
            begin
                $error("event_time: expected %0h, got %0h", want.event_time, m_axis_tdata);
                mismatches++;
            end
            if (m_axis_tuser[0] !== want.no_event)
            begin
                $error("no_event: expected %0b, got %0b", want.no_event, m_axis_tuser[0]);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_draw_result();
        if (hold_seen != hold_requests)
        begin
            hold_seen     <= hold_requests;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= !receiver_stalls();
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin
        plan_row_t    p;
        draw_result_t want;
        flow_mode_t   phase_modes [4];
        logic [31:0]  phase_seeds [4];
        int           phase_start;
        int           pick;
        bit           held;
        bit           paused;
        phase_modes = '{FLOW_FREE, FLOW_SENDER_IDLE, FLOW_RECEIVER_STALL, FLOW_BOTH};
        phase_seeds = '{32'h0, 32'hFFFF_FFFF, $urandom, 32'd1};
        held   = 1'b0;
        paused = 1'b0;
        gen_state = SEED_DEFAULT;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        fill_table();

        foreach (opening_plan[i])
        begin
            p = opening_plan[i];
            want.event_time = p.want_time;
            want.no_event   = p.want_none;
            if (p.kind == REQ_LOAD)
                send_req(make_load(p.row, p.tick, p.surv), 1'b0, '0);
            else
                send_req(make_draw(p.row, p.npts), p.typed, want);
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            write_seed(phase_seeds[ph]);
            flow_mode   = phase_modes[ph];
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                if (flow_mode == FLOW_RECEIVER_STALL && !held &&
                    items_sent - phase_start > PHASE_ITEMS / 2)
                begin
                    hold_requests <= hold_requests + 1;
                    held = 1'b1;
                end
                if (flow_mode == FLOW_SENDER_IDLE && !paused &&
                    items_sent - phase_start > PHASE_ITEMS / 2)
                begin
                    drain();
                    paused = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    send_curve();
                else if (pick < 85)
                    send_req(make_load(ROW_W'($urandom), $urandom,
                                       ($urandom_range(0, 3) == 0) ? 17'd65536
                                           : SURV_W'($urandom_range(0, 131071))),
                             1'b0, '0);
                else
                    send_req(make_draw(ROW_W'($urandom),
                                       ($urandom_range(0, 24) == 0)
                                           ? COUNT_W'($urandom_range(65, 2047))
                                           : COUNT_W'($urandom_range(0, 64))),
                             1'b0, '0);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ===== survival_curve_sampler.f =====
+incdir+rtl
rtl/scs_pkg.sv
rtl/scs_ram.sv
rtl/scs_urng.sv
rtl/scs_walker.sv
rtl/survival_curve_sampler.sv
rtl/scs_checker.sv
verif/tb.sv
